FILE: src/psl_pkg.sv
// ----------------------------------------------------------------------------
// psl_pkg
// Shared types and constants of the sieve prime lister.
// ----------------------------------------------------------------------------
package psl_pkg;

  localparam int unsigned LIMIT_W = 8;
  localparam int unsigned IDX_W   = LIMIT_W + 1;
  localparam int unsigned BASE_W  = 5;
  localparam int unsigned SQ_W    = 2 * BASE_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EMPTY,
    ST_INIT,
    ST_BASE_RD,
    ST_BASE_CHK,
    ST_MARK,
    ST_SCAN,
    ST_FLUSH
  } psl_state_e;

  typedef struct packed {
    logic load;
    logic init_step;
    logic base_next;
    logic mark_start;
    logic mark_step;
    logic scan_start;
    logic scan_en;
    logic flush;
    logic empty;
  } psl_cmd_t;

  typedef struct packed {
    logic small_limit;
    logic init_done;
    logic base_over;
    logic flag_set;
    logic mark_done;
    logic scan_done;
    logic out_free;
  } psl_stat_t;

endpackage

FILE: src/psl_chan_if.sv
// ----------------------------------------------------------------------------
// psl_chan_if
// Request and result channels of the sieve prime lister.
// ----------------------------------------------------------------------------
interface psl_req_if;
  logic       valid;
  logic       ready;
  logic [7:0] limit;

  modport source (output valid, output limit, input ready);
  modport sink   (input valid, input limit, output ready);
endinterface

interface psl_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] prime;
  logic       last;
  logic       none_found;

  modport source (output valid, output prime, output last, output none_found, input ready);
  modport sink   (input valid, input prime, input last, input none_found, output ready);
endinterface

FILE: src/psl_ctrl.sv
// ----------------------------------------------------------------------------
// psl_ctrl
// Sequencer: init, base check, multiple marking, scan and flush phases.
// ----------------------------------------------------------------------------
module psl_ctrl
  import psl_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      req_valid_i,
  output logic      req_ready_o,
  input  psl_stat_t stat_i,
  output psl_cmd_t  cmd_o
);

  psl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          state_d = stat_i.small_limit ? ST_EMPTY : ST_INIT;
        end
      end
      ST_EMPTY: begin
        if (stat_i.out_free) state_d = ST_IDLE;
      end
      ST_INIT: begin
        if (stat_i.init_done) state_d = ST_BASE_RD;
      end
      ST_BASE_RD: begin
        state_d = stat_i.base_over ? ST_SCAN : ST_BASE_CHK;
      end
      ST_BASE_CHK: begin
        state_d = stat_i.flag_set ? ST_MARK : ST_BASE_RD;
      end
      ST_MARK: begin
        if (stat_i.mark_done) state_d = ST_BASE_RD;
      end
      ST_SCAN: begin
        if (stat_i.scan_done) state_d = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (stat_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        cmd_o.load  = req_valid_i;
      end
      ST_EMPTY:    cmd_o.empty = 1'b1;
      ST_INIT:     cmd_o.init_step = 1'b1;
      ST_BASE_RD:  cmd_o.scan_start = stat_i.base_over;
      ST_BASE_CHK: begin
        cmd_o.mark_start = stat_i.flag_set;
        cmd_o.base_next  = !stat_i.flag_set;
      end
      ST_MARK: begin
        cmd_o.mark_step = !stat_i.mark_done;
        cmd_o.base_next = stat_i.mark_done;
      end
      ST_SCAN:     cmd_o.scan_en = 1'b1;
      ST_FLUSH:    cmd_o.flush = 1'b1;
      default: begin
        cmd_o       = '0;
        req_ready_o = 1'b0;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_empty_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMPTY && stat_i.out_free) |=> state_q == ST_IDLE)
    else $error("empty result beat did not return to idle");

  a_start_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && req_valid_i && !stat_i.small_limit) |=> state_q == ST_INIT)
    else $error("accepted request did not start init");

  a_flush_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FLUSH && stat_i.out_free) |=> state_q == ST_IDLE)
    else $error("final beat did not return to idle");
`endif

endmodule

FILE: src/psl_dpath.sv
// ----------------------------------------------------------------------------
// psl_dpath
// Flag store, index counters, scan pipeline and result register.
// ----------------------------------------------------------------------------
module psl_dpath
  import psl_pkg::*;
#(
  parameter int unsigned MAX_LIMIT = 255
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [LIMIT_W-1:0] limit_i,
  input  psl_cmd_t           cmd_i,
  output psl_stat_t          stat_o,
  input  logic               rsp_ready_i,
  output logic               rsp_valid_o,
  output logic [LIMIT_W-1:0] rsp_prime_o,
  output logic               rsp_last_o,
  output logic               rsp_none_found_o
);

  localparam logic [LIMIT_W-1:0] MaxLim = LIMIT_W'(MAX_LIMIT);
  localparam int unsigned        Depth  = 2 ** LIMIT_W;

  logic               flags_q [Depth];
  logic               rd_data_q;
  logic [LIMIT_W-1:0] rd_addr;
  logic               we;
  logic [LIMIT_W-1:0] wa;
  logic               wd;

  logic [LIMIT_W-1:0] lim_sat;
  logic [LIMIT_W-1:0] n_q;
  logic [IDX_W-1:0]   n_ext;
  logic [IDX_W-1:0]   k_q, k_d;
  logic [BASE_W-1:0]  i_q, i_d;
  logic [IDX_W-1:0]   j_q, j_d;
  logic [SQ_W-1:0]    sq;
  logic               rdv_q, rdv_d;
  logic [LIMIT_W-1:0] rd_k_q, rd_k_d;
  logic [LIMIT_W-1:0] pend_q, pend_d;
  logic               pend_v_q, pend_v_d;

  logic               out_valid_q, out_valid_d;
  logic [LIMIT_W-1:0] out_prime_q, out_prime_d;
  logic               out_last_q, out_last_d;
  logic               out_none_q, out_none_d;

  logic               out_free;
  logic               hit, stall, issue;
  logic               push_mid, push_last, push_empty;

  assign lim_sat  = (limit_i > MaxLim) ? MaxLim : limit_i;
  assign n_ext    = {1'b0, n_q};
  assign sq       = SQ_W'(i_q) * SQ_W'(i_q);
  assign out_free = !out_valid_q || rsp_ready_i;

  assign hit   = cmd_i.scan_en && rdv_q && rd_data_q;
  assign stall = hit && pend_v_q && !out_free;
  assign issue = cmd_i.scan_en && !stall && (k_q <= n_ext);

  assign push_mid   = hit && pend_v_q && !stall;
  assign push_last  = cmd_i.flush && out_free;
  assign push_empty = cmd_i.empty && out_free;

  assign stat_o.small_limit = lim_sat < LIMIT_W'(2);
  assign stat_o.init_done   = k_q == n_ext;
  assign stat_o.base_over   = sq > SQ_W'(n_q);
  assign stat_o.flag_set    = rd_data_q;
  assign stat_o.mark_done   = j_q > n_ext;
  assign stat_o.scan_done   = (k_q > n_ext) && !rdv_q;
  assign stat_o.out_free    = out_free;

  // flag store
  assign we = cmd_i.init_step || cmd_i.mark_step;
  assign wa = cmd_i.init_step ? k_q[LIMIT_W-1:0] : j_q[LIMIT_W-1:0];
  assign wd = cmd_i.init_step && (k_q >= IDX_W'(2));

  always_comb begin
    if (cmd_i.scan_en) begin
      rd_addr = stall ? rd_k_q : k_q[LIMIT_W-1:0];
    end else begin
      rd_addr = LIMIT_W'(i_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      flags_q[wa] <= wd;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= flags_q[rd_addr];
  end

  // counters and scan pipeline
  always_comb begin
    k_d      = k_q;
    i_d      = i_q;
    j_d      = j_q;
    rdv_d    = rdv_q;
    rd_k_d   = rd_k_q;
    pend_d   = pend_q;
    pend_v_d = pend_v_q;
    if (cmd_i.load) begin
      k_d = '0;
      i_d = BASE_W'(2);
    end
    if (cmd_i.init_step) k_d = k_q + IDX_W'(1);
    if (cmd_i.base_next) i_d = i_q + BASE_W'(1);
    if (cmd_i.mark_start) j_d = IDX_W'(sq);
    if (cmd_i.mark_step) j_d = j_q + IDX_W'(i_q);
    if (cmd_i.scan_start) begin
      k_d      = IDX_W'(2);
      rdv_d    = 1'b0;
      pend_v_d = 1'b0;
    end
    if (cmd_i.scan_en && !stall) begin
      rdv_d  = issue;
      rd_k_d = k_q[LIMIT_W-1:0];
      if (issue) k_d = k_q + IDX_W'(1);
      if (hit) begin
        pend_d   = rd_k_q;
        pend_v_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q      <= '0;
      i_q      <= '0;
      j_q      <= '0;
      rdv_q    <= 1'b0;
      pend_v_q <= 1'b0;
    end else begin
      k_q      <= k_d;
      i_q      <= i_d;
      j_q      <= j_d;
      rdv_q    <= rdv_d;
      pend_v_q <= pend_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_k_q <= rd_k_d;
    pend_q <= pend_d;
    if (cmd_i.load) n_q <= lim_sat;
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q && !rsp_ready_i;
    out_prime_d = out_prime_q;
    out_last_d  = out_last_q;
    out_none_d  = out_none_q;
    if (push_empty) begin
      out_valid_d = 1'b1;
      out_prime_d = '0;
      out_last_d  = 1'b1;
      out_none_d  = 1'b1;
    end else if (push_last || push_mid) begin
      out_valid_d = 1'b1;
      out_prime_d = pend_q;
      out_last_d  = push_last;
      out_none_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_prime_q <= out_prime_d;
    out_last_q  <= out_last_d;
    out_none_q  <= out_none_d;
  end

  assign rsp_valid_o      = out_valid_q;
  assign rsp_prime_o      = out_prime_q;
  assign rsp_last_o       = out_last_q;
  assign rsp_none_found_o = out_none_q;

`ifndef ASSERT_OFF
  a_mark_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mark_step |-> j_q <= n_ext)
    else $error("multiple write beyond limit");

  a_empty_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_none_q) |-> (out_prime_q == '0 && out_last_q))
    else $error("empty beat carries a prime or is not last");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |=> (rd_k_q == $past(rd_k_q) && k_q == $past(k_q)))
    else $error("scan advanced while stalled");

  a_base_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    i_q <= BASE_W'(16))
    else $error("base index past square root bound");
`endif

endmodule

FILE: src/prime_sieve_lister_core.sv
// Sequence: a limit below 2 gives a single empty beat from the empty state; otherwise
// an init pass writes every flag up to the limit, each base is read and checked until
// its square exceeds the limit, a base whose flag is set clears its multiples from its
// square, then a scan lists the primes and a flush sends the last one.
// One request at a time, accepted the cycle after the final beat is registered; a result
// stall holds the scan while a beat waits. Reset clears control, not the flag store.
// ----------------------------------------------------------------------------
// prime_sieve_lister_core
// Lists all primes up to a requested limit with a sieve on a one-bit flag store.
// ----------------------------------------------------------------------------
module prime_sieve_lister_core
  import psl_pkg::*;
#(
  parameter int unsigned MAX_LIMIT = 255
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  psl_req_if.sink    req_i,
  psl_rsp_if.source  rsp_o
);

  psl_cmd_t  cmd;
  psl_stat_t stat;
  logic      req_ready;

  psl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  psl_dpath #(
    .MAX_LIMIT (MAX_LIMIT)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .limit_i          (req_i.limit),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .rsp_ready_i      (rsp_o.ready),
    .rsp_valid_o      (rsp_o.valid),
    .rsp_prime_o      (rsp_o.prime),
    .rsp_last_o       (rsp_o.last),
    .rsp_none_found_o (rsp_o.none_found)
  );

  assign req_i.ready = req_ready;

endmodule
